// ===== src/uvcd_pkg.sv =====
// ----------------------------------------------------------------------------
// uvcd_pkg
// Types and constants shared by the payload deframer modules.
// ----------------------------------------------------------------------------
package uvcd_pkg;

    // command codes
    localparam logic CMD_BYTE     = 1'b0;
    localparam logic CMD_CONSUMED = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_FRAME   = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;

    // payload header rules
    localparam logic [7:0]  HDR_MIN_LEN = 8'd2;
    localparam logic [7:0]  HDR_MAX_LEN = 8'd12;
    localparam logic [3:0]  HDR_BASE    = 4'd2;
    localparam logic [3:0]  PTS_LEN     = 4'd4;
    localparam logic [3:0]  SCR_LEN     = 4'd6;
    localparam logic [11:0] PKT_MIN_LEN = 12'd2;

    // header flag bits of the second byte
    localparam int BIT_FID = 0;
    localparam int BIT_EOF = 1;
    localparam int BIT_PTS = 2;
    localparam int BIT_SCR = 3;
    localparam int BIT_RES = 4;

    localparam logic [1:0]  FID_NONE       = 2'd2;
    localparam logic [3:0]  QUEUE_SAT      = 4'd15;
    localparam logic [11:0] BYTE_INDEX_MAX = 12'd4095;

    // result queue geometry
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_SLOTS = 1 << QUEUE_AW;

    typedef struct packed {
        logic        command;
        logic [7:0]  data_byte;
        logic [11:0] packet_length;
        logic        first_in_packet;
        logic        last_in_packet;
    } uvcd_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] frames_done;
        logic [3:0]  queued_frames;
        logic        last_result;
    } uvcd_out_t;

    // results of one input transaction, res0 first
    typedef struct packed {
        logic [1:0] count;
        uvcd_out_t  res0;
        uvcd_out_t  res1;
    } uvcd_step_res_t;

endpackage

// ===== src/uvcd_in_stage.sv =====
// ----------------------------------------------------------------------------
// uvcd_in_stage
// Input register: holds one transaction until the step logic takes it.
// ----------------------------------------------------------------------------
module uvcd_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  uvcd_pkg::uvcd_in_t s_data,
    input  logic              take,
    output logic              in_vld,
    output uvcd_pkg::uvcd_in_t in_data
);
    import uvcd_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    uvcd_in_t data_reg;

    assign s_ready = !vld_reg || take;
    assign in_vld  = vld_reg;
    assign in_data = data_reg;

    always_comb begin
        vld_next = vld_reg;
        if (s_valid && s_ready) begin
            vld_next = 1'b1;
        end else if (take) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

// ===== src/uvcd_step.sv =====
// ----------------------------------------------------------------------------
// uvcd_step
// Deframer state and the per-byte header check, close and drop decisions.
// ----------------------------------------------------------------------------
module uvcd_step #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step_en,
    input  uvcd_pkg::uvcd_in_t      step_in,
    output uvcd_pkg::uvcd_step_res_t step_res
);
    import uvcd_pkg::*;

    localparam logic [3:0] DEPTH_LIMIT = 4'(QUEUE_DEPTH);

    logic [1:0]  fid_reg,        fid_next;
    logic        frame_open_reg, frame_open_next;
    logic [3:0]  qcount_reg,     qcount_next;
    logic        nonempty_reg,   nonempty_next;
    logic [15:0] fcount_reg,     fcount_next;
    logic [11:0] index_reg,      index_next;
    logic [3:0]  hdr_len_reg,    hdr_len_next;
    logic        dropping_reg,   dropping_next;
    logic        eof_reg,        eof_next;
    logic [7:0]  held_reg;

    logic [11:0] idx;
    logic [3:0]  expect_len;
    logic        hdr_candidate;
    logic        hold_en;
    uvcd_out_t   close_res;
    uvcd_step_res_t res;

    function automatic uvcd_out_t make_res(logic [1:0] kind, logic [7:0] data,
                                           logic [15:0] fc, logic [3:0] qc);
        uvcd_out_t r;
        r.kind          = kind;
        r.out_byte      = data;
        r.frames_done   = fc;
        r.queued_frames = qc;
        r.last_result   = 1'b0;
        return r;
    endfunction

    assign idx = step_in.first_in_packet ? 12'd0 : index_reg;

    assign expect_len = HDR_BASE
                      + (step_in.data_byte[BIT_PTS] ? PTS_LEN : 4'd0)
                      + (step_in.data_byte[BIT_SCR] ? SCR_LEN : 4'd0);

    assign hdr_candidate = (step_in.packet_length > PKT_MIN_LEN)
                        && (step_in.data_byte >= HDR_MIN_LEN)
                        && (step_in.data_byte <= HDR_MAX_LEN)
                        && ({4'd0, step_in.data_byte} <= step_in.packet_length)
                        && !step_in.last_in_packet;

    always_comb begin
        fid_next        = fid_reg;
        frame_open_next = frame_open_reg;
        qcount_next     = qcount_reg;
        nonempty_next   = nonempty_reg;
        fcount_next     = fcount_reg;
        index_next      = index_reg;
        hdr_len_next    = hdr_len_reg;
        dropping_next   = dropping_reg;
        eof_next        = eof_reg;
        hold_en         = 1'b0;
        res             = '0;
        close_res       = '0;

        if (step_in.command == CMD_CONSUMED) begin
            if (qcount_reg != 4'd0) begin
                qcount_next = qcount_reg - 4'd1;
            end
        end else begin
            if (idx == 12'd0) begin
                hdr_len_next  = 4'd0;
                eof_next      = 1'b0;
                dropping_next = 1'b0;
                if (!frame_open_reg && qcount_reg >= DEPTH_LIMIT) begin
                    dropping_next = 1'b1;
                    res.count = 2'd1;
                    res.res0  = make_res(KIND_DROP, 8'd0, fcount_reg, qcount_reg);
                end else begin
                    frame_open_next = 1'b1;
                    if (hdr_candidate) begin
                        hold_en      = 1'b1;
                        hdr_len_next = step_in.data_byte[3:0];
                    end else begin
                        nonempty_next = 1'b1;
                        res.count = 2'd1;
                        res.res0  = make_res(KIND_PAYLOAD, step_in.data_byte,
                                             fcount_reg, qcount_reg);
                    end
                end
            end else if (dropping_reg) begin
                // rest of a dropped packet
            end else if (idx == 12'd1 && hdr_len_reg != 4'd0) begin
                if (hdr_len_reg == expect_len && !step_in.data_byte[BIT_RES]) begin
                    if (step_in.data_byte[BIT_EOF]) begin
                        eof_next = 1'b1;
                    end else if ({1'b0, step_in.data_byte[BIT_FID]} != fid_reg
                                 && nonempty_reg) begin
                        fcount_next     = fcount_reg + 16'd1;
                        qcount_next     = (qcount_reg < QUEUE_SAT) ? qcount_reg + 4'd1
                                                                   : qcount_reg;
                        frame_open_next = 1'b0;
                        nonempty_next   = 1'b0;
                        res.count = 2'd1;
                        res.res0  = make_res(KIND_FRAME, 8'd0, fcount_next, qcount_next);
                    end
                    fid_next = {1'b0, step_in.data_byte[BIT_FID]};
                end else begin
                    // bad header: release the held byte and this one as payload
                    hdr_len_next  = 4'd0;
                    nonempty_next = 1'b1;
                    res.count = 2'd2;
                    res.res0  = make_res(KIND_PAYLOAD, held_reg, fcount_reg, qcount_reg);
                    res.res1  = make_res(KIND_PAYLOAD, step_in.data_byte,
                                         fcount_reg, qcount_reg);
                end
            end else if (idx < {8'd0, hdr_len_reg}) begin
                // header byte: skip
            end else begin
                nonempty_next = 1'b1;
                res.count = 2'd1;
                res.res0  = make_res(KIND_PAYLOAD, step_in.data_byte,
                                     fcount_next, qcount_next);
            end

            if (step_in.last_in_packet) begin
                if (!dropping_next && eof_next && nonempty_next) begin
                    fcount_next     = fcount_next + 16'd1;
                    qcount_next     = (qcount_next < QUEUE_SAT) ? qcount_next + 4'd1
                                                                : qcount_next;
                    frame_open_next = 1'b0;
                    nonempty_next   = 1'b0;
                    close_res = make_res(KIND_FRAME, 8'd0, fcount_next, qcount_next);
                    // at most one result precedes an end-of-frame close
                    if (res.count == 2'd0) begin
                        res.res0 = close_res;
                    end else begin
                        res.res1 = close_res;
                    end
                    res.count = res.count + 2'd1;
                end
                eof_next      = 1'b0;
                dropping_next = 1'b0;
                hdr_len_next  = 4'd0;
                index_next    = 12'd0;
            end else begin
                index_next = (idx < BYTE_INDEX_MAX) ? idx + 12'd1 : BYTE_INDEX_MAX;
            end
        end

        if (res.count == 2'd1) begin
            res.res0.last_result = 1'b1;
        end else if (res.count == 2'd2) begin
            res.res1.last_result = 1'b1;
        end
    end

    assign step_res = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fid_reg        <= FID_NONE;
            frame_open_reg <= 1'b0;
            qcount_reg     <= 4'd0;
            nonempty_reg   <= 1'b0;
            fcount_reg     <= 16'd0;
            index_reg      <= 12'd0;
            hdr_len_reg    <= 4'd0;
            dropping_reg   <= 1'b0;
            eof_reg        <= 1'b0;
        end else if (step_en) begin
            fid_reg        <= fid_next;
            frame_open_reg <= frame_open_next;
            qcount_reg     <= qcount_next;
            nonempty_reg   <= nonempty_next;
            fcount_reg     <= fcount_next;
            index_reg      <= index_next;
            hdr_len_reg    <= hdr_len_next;
            dropping_reg   <= dropping_next;
            eof_reg        <= eof_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && hold_en) begin
            held_reg <= step_in.data_byte;
        end
    end

endmodule

// ===== src/uvcd_out_queue.sv =====
// ----------------------------------------------------------------------------
// uvcd_out_queue
// Result queue: up to two results in per transaction, one out per ready cycle.
// ----------------------------------------------------------------------------
module uvcd_out_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push_en,
    input  uvcd_pkg::uvcd_step_res_t push_res,
    output logic                     room,
    output logic                     m_valid,
    input  logic                     m_ready,
    output uvcd_pkg::uvcd_out_t      m_data
);
    import uvcd_pkg::*;

    localparam logic [QUEUE_AW:0] ROOM_LIMIT = (QUEUE_AW + 1)'(QUEUE_SLOTS - 2);

    uvcd_out_t           slot_reg [QUEUE_SLOTS];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg,  count_next;
    logic [QUEUE_AW:0]   push_n;
    logic                pop;

    assign room    = count_reg <= ROOM_LIMIT;
    assign m_valid = count_reg != '0;
    assign m_data  = slot_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign push_n  = push_en ? (QUEUE_AW + 1)'(push_res.count) : '0;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_n[QUEUE_AW-1:0];
        rd_ptr_next = rd_ptr_reg + (pop ? (QUEUE_AW)'(1) : '0);
        count_next  = count_reg + push_n - (pop ? (QUEUE_AW + 1)'(1) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en && push_res.count != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push_res.res0;
        end
        if (push_en && push_res.count == 2'd2) begin
            slot_reg[wr_ptr_reg + (QUEUE_AW)'(1)] <= push_res.res1;
        end
    end

endmodule

// ===== src/uvc_payload_deframer_core.sv =====
// ----------------------------------------------------------------------------
// uvc_payload_deframer_core
// Strips USB video payload headers and marks frame boundaries.
// ----------------------------------------------------------------------------
// A transaction is taken into an input register, decided in one pass by the
// step logic, and its zero, one or two results go into a four-entry result
// queue. The block takes one transaction per cycle as long as each yields at
// most one result and the result port is not stalled; the port sends one
// result per cycle while m_ready is high, so the two results of one byte (a
// rejected header, or a payload byte followed by an end-of-frame close) leave
// it one after the other. The input side stalls while the queue holds more
// than two results. Results pass the input register, then the result queue.
module uvc_payload_deframer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  uvcd_pkg::uvcd_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output uvcd_pkg::uvcd_out_t m_data
);
    import uvcd_pkg::*;

    logic           in_vld;
    uvcd_in_t       in_data;
    logic           room;
    logic           step_en;
    uvcd_step_res_t step_res;

    assign step_en = in_vld && room;

    uvcd_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .take    (step_en),
        .in_vld  (in_vld),
        .in_data (in_data)
    );

    uvcd_step #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .step_in  (in_data),
        .step_res (step_res)
    );

    uvcd_out_queue u_out_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_en  (step_en),
        .push_res (step_res),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== src/uvcd_port_check.sv =====
// ----------------------------------------------------------------------------
// uvcd_port_check
// Port-level checks for the payload deframer, bound to the top level.
// ----------------------------------------------------------------------------
module uvcd_port_check (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input uvcd_pkg::uvcd_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input uvcd_pkg::uvcd_out_t m_data
);
    import uvcd_pkg::*;

    // a stalled result transaction holds
    a_m_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction changed while stalled");

    a_kind_legal : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.kind == KIND_PAYLOAD || m_data.kind == KIND_FRAME
                     || m_data.kind == KIND_DROP))
        else $error("illegal result kind");

    a_byte_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_PAYLOAD |-> m_data.out_byte == 8'd0)
        else $error("non-payload result carries a byte");

    // a closed frame always sits in the queue
    a_frame_queued : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_FRAME |-> m_data.queued_frames != 4'd0)
        else $error("frame complete with empty queue count");

    // back-to-back frame results advance the frame count by one
    a_frame_count : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.kind == KIND_FRAME ##1
        m_valid && m_data.kind == KIND_FRAME
        |-> m_data.frames_done == $past(m_data.frames_done) + 16'd1)
        else $error("frame count skipped");

endmodule

bind uvc_payload_deframer_core uvcd_port_check u_port_check (.*);
